// ===== hw/rtl/rtcv_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcv_pkg
// Shared types, widths, register map and helpers for the return temperature
// curve valve step unit.
// ----------------------------------------------------------------------------
package rtcv_pkg;

  localparam int TempW = 13;
  localparam int TolW  = 10;
  localparam int TimeW = 16;
  localparam int GainW = 16;
  localparam int TagW  = 3;
  localparam int DirW  = 2;

  // Curve span and differences need one bit more than a temperature.
  localparam int SpanW   = TempW + 1;
  localparam int ProdW   = 2 * SpanW;
  localparam int ExcessW = TempW;
  localparam int RunProdW = GainW + ExcessW;

  // The quotient never needs more than TempW bits; two extra bits plus an
  // overflow flag is enough to saturate it.
  localparam int QuoW         = 15;
  localparam int BitsPerStage = 3;
  localparam int DivStages    = QuoW / BitsPerStage;

  typedef enum logic [DirW-1:0] {
    DIR_HALT  = 2'd0,
    DIR_CLOSE = 2'd1,
    DIR_OPEN  = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    REG_FLOW_LOW   = 3'd0,
    REG_FLOW_HIGH  = 3'd1,
    REG_RET_LOW    = 3'd2,
    REG_RET_HIGH   = 3'd3,
    REG_TOL        = 3'd4,
    REG_MIN_TIME   = 3'd5,
    REG_CLOSE_GAIN = 3'd6,
    REG_OPEN_GAIN  = 3'd7
  } reg_idx_t;

  localparam logic signed [TempW-1:0] RST_FLOW_LOW   = 13'sd640;
  localparam logic signed [TempW-1:0] RST_FLOW_HIGH  = 13'sd1200;
  localparam logic signed [TempW-1:0] RST_RET_LOW    = 13'sd480;
  localparam logic signed [TempW-1:0] RST_RET_HIGH   = 13'sd800;
  localparam logic [TolW-1:0]         RST_TOL        = 10'd32;
  localparam logic [TimeW-1:0]        RST_MIN_TIME   = 16'd32;
  localparam logic [GainW-1:0]        RST_CLOSE_GAIN = 16'd256;
  localparam logic [GainW-1:0]        RST_OPEN_GAIN  = 16'd256;

  // Marker for a faulty sensor: -99.9 K in 1/16 K.
  localparam logic signed [TempW-1:0] ERROR_MARK = -13'sd1598;

  typedef struct packed {
    logic signed [TempW-1:0] flow_low;
    logic signed [TempW-1:0] flow_high;
    logic signed [TempW-1:0] ret_low;
    logic signed [TempW-1:0] ret_high;
    logic [TolW-1:0]         tol;
    logic [TimeW-1:0]        min_time;
    logic [GainW-1:0]        close_gain;
    logic [GainW-1:0]        open_gain;
  } cfg_t;

  // Per-request fields that ride along the pipeline.
  typedef struct packed {
    logic [TagW-1:0]         tag;
    logic signed [TempW-1:0] ret;
    logic                    err;
    logic                    summer;
  } side_t;

  function automatic logic signed [SpanW-1:0] curve_span(input cfg_t c);
    logic signed [SpanW-1:0] hi;
    logic signed [SpanW-1:0] lo;
    hi = SpanW'(c.flow_high);
    lo = SpanW'(c.flow_low);
    return hi - lo;
  endfunction

endpackage

// ===== hw/rtl/rtcv_front.sv =====
// ----------------------------------------------------------------------------
// rtcv_front
// Curve differences and the interpolation numerator, two register stages.
// ----------------------------------------------------------------------------
module rtcv_front import rtcv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    valid_i,
  input  side_t                   side_i,
  input  logic signed [TempW-1:0] flow_i,
  output logic                    valid_o,
  output side_t                   side_o,
  output logic signed [ProdW-1:0] num_o
);

  logic                    valid1_r;
  side_t                   side1_r;
  logic signed [SpanW-1:0] dr_r;
  logic signed [SpanW-1:0] df_r;
  logic                    valid2_r;
  side_t                   side2_r;
  logic signed [ProdW-1:0] num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      valid1_r <= valid_i;
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    side1_r <= side_i;
    dr_r    <= SpanW'(cfg.ret_high) - SpanW'(cfg.ret_low);
    df_r    <= SpanW'(flow_i) - SpanW'(cfg.flow_low);
    side2_r <= side1_r;
    num_r   <= dr_r * df_r;
  end

  assign valid_o = valid2_r;
  assign side_o  = side2_r;
  assign num_o   = num_r;

endmodule

// ===== hw/rtl/rtcv_div.sv =====
// ----------------------------------------------------------------------------
// rtcv_div
// Pipelined restoring divider: numerator over curve span, a few quotient
// bits per stage, saturating through an overflow flag.
// ----------------------------------------------------------------------------
module rtcv_div import rtcv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    valid_i,
  input  side_t                   side_i,
  input  logic signed [ProdW-1:0] num_i,
  output logic                    valid_o,
  output side_t                   side_o,
  output logic [QuoW-1:0]         quo_o,
  output logic                    ovf_o
);

  logic signed [SpanW-1:0] span;
  logic [ProdW-1:0]        den_ext;

  logic             valid_r [DivStages];
  side_t            side_r  [DivStages];
  logic [QuoW-1:0]  quo_r   [DivStages];
  logic             ovf_r   [DivStages];
  logic [ProdW-1:0] rem_r   [DivStages-1];

  // Only a positive span reaches the quotient, so its low bits suffice.
  assign span    = curve_span(cfg);
  assign den_ext = ProdW'(span[SpanW-2:0]);

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic             valid_in;
    side_t            side_in;
    logic [ProdW-1:0] rem_in;
    logic [QuoW-1:0]  quo_in;
    logic             ovf_in;
    logic [ProdW-1:0] rem_c;
    logic [QuoW-1:0]  quo_c;

    if (s == 0) begin : g_first
      // A numerator at or below zero gives a target at the low point,
      // the same as a zero quotient.
      assign valid_in = valid_i;
      assign side_in  = side_i;
      assign rem_in   = (num_i > 0) ? $unsigned(num_i) : '0;
      assign quo_in   = '0;
      assign ovf_in   = rem_in >= (den_ext << QuoW);
    end else begin : g_next
      assign valid_in = valid_r[s-1];
      assign side_in  = side_r[s-1];
      assign rem_in   = rem_r[s-1];
      assign quo_in   = quo_r[s-1];
      assign ovf_in   = ovf_r[s-1];
    end

    always_comb begin
      rem_c = rem_in;
      quo_c = quo_in;
      for (int j = 0; j < BitsPerStage; j++) begin
        if (rem_c >= (den_ext << (QuoW - 1 - BitsPerStage * s - j))) begin
          rem_c = rem_c - (den_ext << (QuoW - 1 - BitsPerStage * s - j));
          quo_c[QuoW - 1 - BitsPerStage * s - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else begin
        valid_r[s] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      side_r[s] <= side_in;
      quo_r[s]  <= quo_c;
      ovf_r[s]  <= ovf_in;
    end

    if (s < DivStages - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[s] <= rem_c;
      end
    end
  end

  assign valid_o = valid_r[DivStages-1];
  assign side_o  = side_r[DivStages-1];
  assign quo_o   = quo_r[DivStages-1];
  assign ovf_o   = ovf_r[DivStages-1];

endmodule

// ===== hw/rtl/rtcv_back.sv =====
// ----------------------------------------------------------------------------
// rtcv_back
// Target clamp, dead band decision, run time product and saturation,
// four register stages ending in the result registers.
// ----------------------------------------------------------------------------
module rtcv_back import rtcv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    valid_i,
  input  side_t                   side_i,
  input  logic [QuoW-1:0]         quo_i,
  input  logic                    ovf_i,
  output logic                    strobe_o,
  output logic [TagW-1:0]         tag_o,
  output logic [DirW-1:0]         dir_o,
  output logic [TimeW-1:0]        time_o,
  output logic signed [TempW-1:0] target_o
);

  localparam int SumW = TempW + 4;
  localparam int RunW = TimeW + RunProdW - 8 + 1;

  // Target stage.
  logic signed [SpanW-1:0] span;
  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  ret_high_ext;
  logic signed [TempW-1:0] target_c;
  logic                    valid_t_r;
  side_t                   side_t_r;
  logic signed [TempW-1:0] target_t_r;

  // Decision stage.
  logic signed [SpanW-1:0] diff;
  logic signed [SpanW-1:0] tol_s;
  logic signed [SpanW-1:0] ex_close;
  logic signed [SpanW-1:0] ex_open;
  logic                    active;
  dir_t                    dir_c;
  logic                    valid_d_r;
  logic [TagW-1:0]         tag_d_r;
  logic signed [TempW-1:0] target_d_r;
  dir_t                    dir_d_r;
  logic [ExcessW-1:0]      excess_d_r;
  logic [GainW-1:0]        gain_d_r;

  // Product stage.
  logic                    valid_m_r;
  logic [TagW-1:0]         tag_m_r;
  logic signed [TempW-1:0] target_m_r;
  dir_t                    dir_m_r;
  logic [RunProdW-1:0]     prod_m_r;

  // Result stage.
  logic [RunW-1:0]         run_sum;
  logic [TimeW-1:0]        time_c;
  logic                    strobe_r;
  logic [TagW-1:0]         tag_r;
  dir_t                    dir_r;
  logic [TimeW-1:0]        time_r;
  logic signed [TempW-1:0] target_r;

  assign span         = curve_span(cfg);
  assign sum          = SumW'(cfg.ret_low) + $signed(SumW'(quo_i));
  assign ret_high_ext = SumW'(cfg.ret_high);

  // The quotient is never negative, so only the upper clamp can act.
  always_comb begin
    priority if (side_i.err) begin
      target_c = ERROR_MARK;
    end else if (side_i.summer) begin
      target_c = '0;
    end else if (span <= 0) begin
      target_c = cfg.ret_low;
    end else if (ovf_i || (sum > ret_high_ext)) begin
      target_c = cfg.ret_high;
    end else begin
      target_c = sum[TempW-1:0];
    end
  end

  assign active   = !side_t_r.err && !side_t_r.summer;
  assign diff     = SpanW'(side_t_r.ret) - SpanW'(target_t_r);
  assign tol_s    = $signed(SpanW'(cfg.tol));
  assign ex_close = diff - tol_s;
  assign ex_open  = -diff - tol_s;

  always_comb begin
    priority if (active && (diff > tol_s)) begin
      dir_c = DIR_CLOSE;
    end else if (active && (diff < -tol_s)) begin
      dir_c = DIR_OPEN;
    end else begin
      dir_c = DIR_HALT;
    end
  end

  assign run_sum = RunW'(cfg.min_time) + RunW'(prod_m_r[RunProdW-1:8]);

  always_comb begin
    if (dir_m_r == DIR_HALT) begin
      time_c = '0;
    end else if (run_sum > RunW'({TimeW{1'b1}})) begin
      time_c = {TimeW{1'b1}};
    end else begin
      time_c = run_sum[TimeW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_t_r <= 1'b0;
      valid_d_r <= 1'b0;
      valid_m_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      valid_t_r <= valid_i;
      valid_d_r <= valid_t_r;
      valid_m_r <= valid_d_r;
      strobe_r  <= valid_m_r;
    end
  end

  always_ff @(posedge clk) begin
    side_t_r   <= side_i;
    target_t_r <= target_c;

    tag_d_r    <= side_t_r.tag;
    target_d_r <= target_t_r;
    dir_d_r    <= dir_c;
    excess_d_r <= (dir_c == DIR_OPEN) ? ex_open[ExcessW-1:0] : ex_close[ExcessW-1:0];
    gain_d_r   <= (dir_c == DIR_OPEN) ? cfg.open_gain : cfg.close_gain;

    tag_m_r    <= tag_d_r;
    target_m_r <= target_d_r;
    dir_m_r    <= dir_d_r;
    prod_m_r   <= gain_d_r * excess_d_r;

    tag_r      <= tag_m_r;
    target_r   <= target_m_r;
    dir_r      <= dir_m_r;
    time_r     <= time_c;
  end

  assign strobe_o = strobe_r;
  assign tag_o    = tag_r;
  assign dir_o    = dir_r;
  assign time_o   = time_r;
  assign target_o = target_r;

endmodule

// ===== hw/rtl/return_temp_curve_valve_step_unit.sv =====
// ----------------------------------------------------------------------------
// return_temp_curve_valve_step_unit: heating curve three-point valve control.
// Accepts one request per cycle.
// busy stays low: an 11-stage pipeline with a 3-bit-per-stage divider.
// Synchronous reset clears pipeline valids and loads register defaults.
// ----------------------------------------------------------------------------
module return_temp_curve_valve_step_unit import rtcv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration port.
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // Request channel.
  input  logic                    start,
  output logic                    busy,
  input  logic [TagW-1:0]         in_valve_number,
  input  logic signed [TempW-1:0] in_flow_temp,
  input  logic signed [TempW-1:0] in_return_temp,
  input  logic                    in_sensor_error,
  input  logic                    in_summer_mode,
  // Result channel.
  output logic                    out_strobe,
  output logic [TagW-1:0]         out_valve_tag,
  output logic [DirW-1:0]         out_direction,
  output logic [TimeW-1:0]        out_motor_time,
  output logic signed [TempW-1:0] out_target_return_temp
);

  cfg_t                    cfg_r;
  reg_idx_t                reg_idx;
  logic                    wr_en;
  side_t                   side_in;
  logic                    accept;

  logic                    f_valid;
  side_t                   f_side;
  logic signed [ProdW-1:0] f_num;
  logic                    d_valid;
  side_t                   d_side;
  logic [QuoW-1:0]         d_quo;
  logic                    d_ovf;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flow_low   <= RST_FLOW_LOW;
      cfg_r.flow_high  <= RST_FLOW_HIGH;
      cfg_r.ret_low    <= RST_RET_LOW;
      cfg_r.ret_high   <= RST_RET_HIGH;
      cfg_r.tol        <= RST_TOL;
      cfg_r.min_time   <= RST_MIN_TIME;
      cfg_r.close_gain <= RST_CLOSE_GAIN;
      cfg_r.open_gain  <= RST_OPEN_GAIN;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FLOW_LOW:   cfg_r.flow_low   <= pwdata[TempW-1:0];
        REG_FLOW_HIGH:  cfg_r.flow_high  <= pwdata[TempW-1:0];
        REG_RET_LOW:    cfg_r.ret_low    <= pwdata[TempW-1:0];
        REG_RET_HIGH:   cfg_r.ret_high   <= pwdata[TempW-1:0];
        REG_TOL:        cfg_r.tol        <= pwdata[TolW-1:0];
        REG_MIN_TIME:   cfg_r.min_time   <= pwdata[TimeW-1:0];
        REG_CLOSE_GAIN: cfg_r.close_gain <= pwdata[GainW-1:0];
        REG_OPEN_GAIN:  cfg_r.open_gain  <= pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Temperature registers read back sign-extended.
  always_comb begin
    unique case (reg_idx)
      REG_FLOW_LOW:   prdata = 32'(cfg_r.flow_low);
      REG_FLOW_HIGH:  prdata = 32'(cfg_r.flow_high);
      REG_RET_LOW:    prdata = 32'(cfg_r.ret_low);
      REG_RET_HIGH:   prdata = 32'(cfg_r.ret_high);
      REG_TOL:        prdata = 32'(cfg_r.tol);
      REG_MIN_TIME:   prdata = 32'(cfg_r.min_time);
      REG_CLOSE_GAIN: prdata = 32'(cfg_r.close_gain);
      REG_OPEN_GAIN:  prdata = 32'(cfg_r.open_gain);
      default:        prdata = '0;
    endcase
  end

  assign accept         = start && !busy;
  assign side_in.tag    = in_valve_number;
  assign side_in.ret    = in_return_temp;
  assign side_in.err    = in_sensor_error;
  assign side_in.summer = in_summer_mode;

  rtcv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .valid_i (accept),
    .side_i  (side_in),
    .flow_i  (in_flow_temp),
    .valid_o (f_valid),
    .side_o  (f_side),
    .num_o   (f_num)
  );

  rtcv_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .valid_i (f_valid),
    .side_i  (f_side),
    .num_i   (f_num),
    .valid_o (d_valid),
    .side_o  (d_side),
    .quo_o   (d_quo),
    .ovf_o   (d_ovf)
  );

  rtcv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .valid_i  (d_valid),
    .side_i   (d_side),
    .quo_i    (d_quo),
    .ovf_i    (d_ovf),
    .strobe_o (out_strobe),
    .tag_o    (out_valve_tag),
    .dir_o    (out_direction),
    .time_o   (out_motor_time),
    .target_o (out_target_return_temp)
  );

endmodule
